@@ sv/nru_pkg.sv @@
`default_nettype none

package nru_pkg;

	// Defaults for the top-level parameters
	localparam int SETS_DEF      = 256;
	localparam int WAYS_DEF      = 8;
	localparam int ADDR_BITS_DEF = 32;

	// Fixed port widths
	localparam int BLK_ADDR_W = 32;
	localparam int MASK_W     = 32;
	localparam int USE_W      = 4;
	localparam int WAY_OUT_W  = 3;
	localparam int WAY_W      = 4;   // enough for up to 16 ways
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_INDEX_MASK  = 1'b0;
	localparam logic REG_WAYS_IN_USE = 1'b1;

	localparam logic [MASK_W-1:0] INDEX_MASK_RST  = 32'h0000_00ff;
	localparam logic [USE_W-1:0]  WAYS_IN_USE_RST = 4'd8;

	typedef struct packed {
		logic rd;
		logic wr_st;
		logic wr_tag;
	} mem_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
	} dec_t;

endpackage

`default_nettype wire

@@ sv/nru_idx.sv @@
`default_nettype none

module nru_idx #(
	parameter int SETS      = nru_pkg::SETS_DEF,
	parameter int ADDR_BITS = nru_pkg::ADDR_BITS_DEF,
	localparam int TAG_W    = (ADDR_BITS < 32) ? ADDR_BITS : 32,
	localparam int IDX_W    = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [TAG_W-1:0]            addr,
	input  logic [nru_pkg::MASK_W-1:0]  mask,
	output logic [IDX_W-1:0]            set_idx,
	output logic                        ready
);
	import nru_pkg::*;

	localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

	logic [MASK_W-1:0] packed_idx;

	// Gather the selected bits: each lands at the count of selected bits below it
	always_comb begin
		logic [4:0] rank;
		packed_idx = '0;
		rank = '0;
		for (int pos = 0; pos < TAG_W; pos++) begin
			rank = 5'($countones(mask & ((32'd1 << pos) - 32'd1)));
			if (mask[pos]) begin
				packed_idx[rank] = addr[pos];
			end
		end
	end

	generate
		if (POW2) begin : g_pow2
			logic [IDX_W-1:0] set_q;
			logic             ld_q;

			always_ff @(posedge clk) begin
				if (go) begin
					set_q <= (SETS > 1) ? packed_idx[IDX_W-1:0] : '0;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ld_q <= 1'b0;
				end else if (go) begin
					ld_q <= 1'b1;
				end
			end

			assign set_idx = set_q;
			assign ready   = ld_q;
		end else begin : g_mod
			// Remainder by SETS via a reciprocal: the quotient is registered first, then the remainder
			localparam int REM_SH = $clog2(SETS);
			localparam logic [63:0] RECIP_FULL =
				((64'd1 << (MASK_W + REM_SH)) / 64'(SETS)) + 64'd1;
			localparam logic [MASK_W:0] RECIP = RECIP_FULL[MASK_W:0];

			logic [MASK_W-1:0] pk_q;
			logic [MASK_W-1:0] quo_q;
			logic [IDX_W-1:0]  rem_q;
			logic [1:0]        cnt_q;
			logic [2*MASK_W:0] quo_prod;
			logic [MASK_W-1:0] back_prod;

			assign quo_prod  = {{(MASK_W+1){1'b0}}, pk_q} * {{MASK_W{1'b0}}, RECIP};
			assign back_prod = quo_q * MASK_W'(SETS);

			always_ff @(posedge clk) begin
				if (go) begin
					pk_q <= packed_idx;
				end
				if (cnt_q == 2'd2) begin
					quo_q <= MASK_W'(quo_prod >> (MASK_W + REM_SH));
				end
				if (cnt_q == 2'd1) begin
					rem_q <= IDX_W'(pk_q - back_prod);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
				end else if (go) begin
					cnt_q <= 2'd2;
				end else if (cnt_q != 2'd0) begin
					cnt_q <= cnt_q - 2'd1;
				end
			end

			assign set_idx = rem_q;
			assign ready   = (cnt_q == 2'd0);
		end
	endgenerate

endmodule

`default_nettype wire

@@ sv/nru_store.sv @@
`default_nettype none

module nru_store #(
	parameter int SETS   = nru_pkg::SETS_DEF,
	parameter int WAYS   = nru_pkg::WAYS_DEF,
	parameter int TAG_W  = nru_pkg::ADDR_BITS_DEF,
	localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1,
	localparam int TR_W  = WAYS * TAG_W,
	localparam int SR_W  = 2 * WAYS
) (
	input  logic              clk,
	input  nru_pkg::mem_ctl_t ctl,
	input  logic [IDX_W-1:0]  rd_idx,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [TR_W-1:0]   tag_wdata,
	input  logic [SR_W-1:0]   st_wdata,
	output logic [TR_W-1:0]   tag_rdata,
	output logic [SR_W-1:0]   st_rdata
);
	import nru_pkg::*;

	// Tag rows: one stored address per way. State rows: {nru bits, valid bits}.
	logic [TR_W-1:0] tag_mem [SETS];
	logic [SR_W-1:0] st_mem  [SETS];
	logic [TR_W-1:0] tag_rd_q;
	logic [SR_W-1:0] st_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_tag) begin
			tag_mem[wr_idx] <= tag_wdata;
		end
		if (ctl.rd) begin
			tag_rd_q <= tag_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_st) begin
			st_mem[wr_idx] <= st_wdata;
		end
		if (ctl.rd) begin
			st_rd_q <= st_mem[rd_idx];
		end
	end

	assign tag_rdata = tag_rd_q;
	assign st_rdata  = st_rd_q;

endmodule

`default_nettype wire

@@ sv/nru_way.sv @@
`default_nettype none

module nru_way #(
	parameter int WAYS   = nru_pkg::WAYS_DEF,
	parameter int TAG_W  = nru_pkg::ADDR_BITS_DEF,
	localparam int TR_W  = WAYS * TAG_W,
	localparam int SR_W  = 2 * WAYS
) (
	input  logic [TAG_W-1:0]          addr,
	input  logic [nru_pkg::USE_W-1:0] use_cfg,
	input  logic [TR_W-1:0]           tag_row,
	input  logic [SR_W-1:0]           st_row,
	output nru_pkg::dec_t             dec,
	output logic [TR_W-1:0]           tag_new,
	output logic [SR_W-1:0]           st_new
);
	import nru_pkg::*;

	logic [4:0]       use_n;
	logic [WAYS-1:0]  valid, nru, inuse, hit_vec, cand;
	logic [WAYS-1:0]  valid_n, nru_n;
	logic             hit_any, cand_any;
	logic [WAY_W-1:0] hit_way, fill_way, way_sel;

	assign valid = st_row[WAYS-1:0];
	assign nru   = st_row[SR_W-1:WAYS];

	// Zero ways means one; more than built means all
	always_comb begin
		if (use_cfg == '0) begin
			use_n = 5'd1;
		end else if ({1'b0, use_cfg} > 5'(WAYS)) begin
			use_n = 5'(WAYS);
		end else begin
			use_n = {1'b0, use_cfg};
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			inuse[w]   = 5'(w) < use_n;
			hit_vec[w] = inuse[w] && valid[w] && (tag_row[w*TAG_W +: TAG_W] == addr);
			cand[w]    = inuse[w] && nru[w];
		end
	end

	assign hit_any  = |hit_vec;
	assign cand_any = |cand;

	// Lowest way wins; with no candidate the fill falls back to way 0
	always_comb begin
		hit_way  = '0;
		fill_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
			if (cand[w]) begin
				fill_way = WAY_W'(w);
			end
		end
	end

	assign way_sel = hit_any ? hit_way : fill_way;

	always_comb begin
		logic sel;
		sel     = 1'b0;
		tag_new = tag_row;
		for (int w = 0; w < WAYS; w++) begin
			sel = (WAY_W'(w) == way_sel);
			if (hit_any) begin
				valid_n[w] = valid[w];
				nru_n[w]   = sel ? 1'b0 : nru[w];
			end else begin
				valid_n[w] = sel ? 1'b1 : valid[w];
				nru_n[w]   = sel ? 1'b0 : (cand_any ? nru[w] : (nru[w] | inuse[w]));
				if (sel) begin
					tag_new[w*TAG_W +: TAG_W] = addr;
				end
			end
		end
	end

	assign st_new  = {nru_n, valid_n};
	assign dec.hit = hit_any;
	assign dec.way = way_sel;

endmodule

`default_nettype wire

@@ sv/nru_set_assoc_cache_lookup.sv @@
// Set-associative lookup with NRU replacement. After reset the block runs a
// clearing pass over every row of the state memory with busy high; registers
// may be written meanwhile. A request is taken when start is high and busy low.
// With a power-of-two SETS the set number is registered, the set's row is read
// from the memories, and in the next cycle all ways are compared and the row
// written back; the next request is taken in that write-back cycle. Any other
// SETS first finds the remainder of the set number (reciprocal multiply, then
// subtract) before the row is read. The result shows on hit and way_used, with
// done high for one cycle, registered in the compare cycle; it cannot be held off.
`default_nettype none

module nru_set_assoc_cache_lookup #(
	parameter int SETS      = nru_pkg::SETS_DEF,
	parameter int WAYS      = nru_pkg::WAYS_DEF,
	parameter int ADDR_BITS = nru_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [nru_pkg::BLK_ADDR_W-1:0]    block_address,
	output logic                              done,
	output logic                              hit,
	output logic [nru_pkg::WAY_OUT_W-1:0]     way_used,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nru_pkg::PADDR_W-1:0]       paddr,
	input  logic [nru_pkg::PDATA_W-1:0]       pwdata,
	output logic [nru_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);
	import nru_pkg::*;

	localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int TR_W  = WAYS * TAG_W;
	localparam int SR_W  = 2 * WAYS;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_IDX  = 2'd2;
	localparam logic [1:0] ST_CMP  = 2'd3;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  set_q;
	logic [TAG_W-1:0]  addr_q;
	logic [MASK_W-1:0] mask_q;
	logic [USE_W-1:0]  ways_q;
	logic              done_q, hit_q;
	logic [WAY_OUT_W-1:0] way_q;

	logic              accept, cfg_wr;
	logic [IDX_W-1:0]  set_idx, wr_idx;
	logic              idx_ready;
	mem_ctl_t          ctl;
	dec_t              dec;
	logic [TR_W-1:0]   tag_rdata, tag_new;
	logic [SR_W-1:0]   st_rdata, st_new, st_wdata;

	// Configuration
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WAYS_IN_USE) ? {{(PDATA_W-USE_W){1'b0}}, ways_q} : mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= INDEX_MASK_RST;
			ways_q <= WAYS_IN_USE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WAYS_IN_USE) begin
				ways_q <= pwdata[USE_W-1:0];
			end else begin
				mask_q <= pwdata;
			end
		end
	end

	// Sequencer; a new request may enter while the previous row is written back
	assign busy   = !(state_q == ST_IDLE || state_q == ST_CMP);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: begin
					if (idx_ready) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= start ? ST_IDX : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= block_address[TAG_W-1:0];
		end
		if (ctl.rd) begin
			set_q <= set_idx;
		end
	end

	nru_idx #(
		.SETS      (SETS),
		.ADDR_BITS (ADDR_BITS)
	) u_idx (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept),
		.addr    (block_address[TAG_W-1:0]),
		.mask    (mask_q),
		.set_idx (set_idx),
		.ready   (idx_ready)
	);

	assign ctl.rd     = (state_q == ST_IDX) && idx_ready;
	assign ctl.wr_st  = (state_q == ST_CLR) || (state_q == ST_CMP);
	assign ctl.wr_tag = (state_q == ST_CMP) && !dec.hit;

	assign wr_idx   = (state_q == ST_CLR) ? clr_q : set_q;
	// Cleared row: all NRU bits set, nothing valid
	assign st_wdata = (state_q == ST_CLR) ? {{WAYS{1'b1}}, {WAYS{1'b0}}} : st_new;

	nru_store #(
		.SETS  (SETS),
		.WAYS  (WAYS),
		.TAG_W (TAG_W)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.rd_idx    (set_idx),
		.wr_idx    (wr_idx),
		.tag_wdata (tag_new),
		.st_wdata  (st_wdata),
		.tag_rdata (tag_rdata),
		.st_rdata  (st_rdata)
	);

	nru_way #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W)
	) u_way (
		.addr    (addr_q),
		.use_cfg (ways_q),
		.tag_row (tag_rdata),
		.st_row  (st_rdata),
		.dec     (dec),
		.tag_new (tag_new),
		.st_new  (st_new)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_CMP);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			hit_q <= dec.hit;
			way_q <= dec.way[WAY_OUT_W-1:0];
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign way_used = way_q;

endmodule

`default_nettype wire

@@ sv/nru_chk.sv @@
`default_nettype none

module nru_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        done,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nru_pkg::PADDR_W-1:0] paddr,
	input  logic [nru_pkg::PDATA_W-1:0] pwdata,
	input  logic [nru_pkg::PDATA_W-1:0] prdata,
	input  logic                        pready
);
	import nru_pkg::*;

	// Port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// A taken request keeps the block busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but busy not raised");

	// Done is never held high
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high on consecutive cycles");

	// Index mask reads back what was just written
	a_mask_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && !pwrite && paddr[2] == REG_INDEX_MASK &&
		$past(psel && penable && pwrite && paddr[2] == REG_INDEX_MASK)
		|-> prdata == $past(pwdata))
		else $error("index mask read-back mismatch");

endmodule

bind nru_set_assoc_cache_lookup nru_chk u_chk (.*);

`default_nettype wire

@@ dv/nru_set_assoc_cache_lookup_checker.sv @@
`timescale 1ns / 100ps

module nru_set_assoc_cache_lookup_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [nru_pkg::BLK_ADDR_W-1:0] block_address,
	input  logic                           done,
	input  logic                           hit,
	input  logic [nru_pkg::WAY_OUT_W-1:0]  way_used,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nru_pkg::PADDR_W-1:0]    paddr,
	input  logic [nru_pkg::PDATA_W-1:0]    pwdata,
	input  logic [nru_pkg::PDATA_W-1:0]    prdata,
	input  logic                           pready,
	output int                             mismatches,
	output int                             outstanding,
	output int                             hits_seen
);

	localparam int SETS  = nru_pkg::SETS_DEF;
	localparam int WAYS  = nru_pkg::WAYS_DEF;
	localparam int LINES = SETS * WAYS;

	typedef struct {
		logic [nru_pkg::BLK_ADDR_W-1:0] addr;
		logic                           hit;
		logic [nru_pkg::WAY_OUT_W-1:0]  way;
	} lookup_result_t;

	lookup_result_t                  expected_lookups[$];
	logic [nru_pkg::MASK_W-1:0]      index_mask_q;
	logic [nru_pkg::USE_W-1:0]       ways_in_use_q;
	logic [nru_pkg::BLK_ADDR_W-1:0]  line_addr [LINES];
	bit                              line_valid [LINES];
	bit                              line_nru [LINES];
	int                              mismatch_count = 0;
	int                              hit_count = 0;

	task automatic report_mismatch(string what, logic [31:0] addr, int got, int want);
		mismatch_count++;
		$display("%0t mismatch: %s (addr %h) got %0d want %0d", $time, what, addr, got, want);
	endtask

	// gather the masked address bits, highest selected position ending up on top
	function automatic int set_of(logic [nru_pkg::BLK_ADDR_W-1:0] addr);
		logic [31:0] gathered;
		gathered = '0;
		for (int pos = 31; pos >= 0; pos--)
			if (index_mask_q[pos])
				gathered = {gathered[30:0], addr[pos]};
		return int'(gathered % SETS);
	endfunction

	task automatic nru_lookup(input logic [nru_pkg::BLK_ADDR_W-1:0] addr,
			output logic hit_o, output logic [nru_pkg::WAY_OUT_W-1:0] way_o);
		int base;
		int use_n;
		bit found;
		base  = set_of(addr) * WAYS;
		use_n = (ways_in_use_q == 0) ? 1 : ((ways_in_use_q > WAYS) ? WAYS : ways_in_use_q);
		found = 0;
		hit_o = 0;
		way_o = '0;
		for (int w = 0; w < use_n && !found; w++)
			if (line_valid[base+w] && line_addr[base+w] == addr) begin
				line_nru[base+w] = 0;
				hit_o = 1;
				way_o = w[nru_pkg::WAY_OUT_W-1:0];
				found = 1;
			end
		for (int w = 0; w < use_n && !found; w++)
			if (line_nru[base+w]) begin
				line_addr[base+w]  = addr;
				line_valid[base+w] = 1;
				line_nru[base+w]   = 0;
				way_o = w[nru_pkg::WAY_OUT_W-1:0];
				found = 1;
			end
		// every in-use way recently used: age every in-use way, refill way 0
		if (!found) begin
			for (int w = 0; w < use_n; w++)
				line_nru[base+w] = 1;
			line_addr[base]  = addr;
			line_valid[base] = 1;
			line_nru[base]   = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t exp_r;
		lookup_result_t new_r;
		logic [31:0]    want_rd;
		if (!arst_n) begin
			index_mask_q  = nru_pkg::INDEX_MASK_RST;
			ways_in_use_q = nru_pkg::WAYS_IN_USE_RST;
			for (int i = 0; i < LINES; i++) begin
				line_addr[i]  = '0;
				line_valid[i] = 0;
				line_nru[i]   = 1;
			end
			expected_lookups.delete();
		end else begin
			// results first: a request taken at this edge is always the newest
			if (done) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result with no request pending", 32'h0, hit, -1);
				end else begin
					exp_r = expected_lookups.pop_front();
					if (hit !== exp_r.hit)
						report_mismatch("hit", exp_r.addr, hit, exp_r.hit);
					else if (hit)
						hit_count++;
					if (way_used !== exp_r.way)
						report_mismatch("way_used", exp_r.addr, way_used, exp_r.way);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == nru_pkg::REG_INDEX_MASK)
						index_mask_q = pwdata;
					else
						ways_in_use_q = pwdata[nru_pkg::USE_W-1:0];
				end else begin
					want_rd = (paddr[2] == nru_pkg::REG_INDEX_MASK) ? index_mask_q :
						{28'h0, ways_in_use_q};
					if (prdata !== want_rd)
						report_mismatch("register readback", {29'h0, paddr}, prdata, want_rd);
				end
			end
			if (start && !busy) begin
				new_r.addr = block_address;
				nru_lookup(block_address, new_r.hit, new_r.way);
				expected_lookups.insert(expected_lookups.size(), new_r);
			end
		end
		outstanding <= expected_lookups.size();
		mismatches  <= mismatch_count;
		hits_seen   <= hit_count;
	end

endmodule

@@ dv/nru_set_assoc_cache_lookup_tb.sv @@
`timescale 1ns / 100ps

module nru_set_assoc_cache_lookup_tb;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int PHASES         = 10;
	localparam int PHASE_REQUESTS = 190;
	localparam int POOL_SIZE      = 40;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [nru_pkg::BLK_ADDR_W-1:0] block_address;
	logic                           done;
	logic                           hit;
	logic [nru_pkg::WAY_OUT_W-1:0]  way_used;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [nru_pkg::PADDR_W-1:0]    paddr;
	logic [nru_pkg::PDATA_W-1:0]    pwdata;
	logic [nru_pkg::PDATA_W-1:0]    prdata;
	logic                           pready;

	int          mismatches;
	int          outstanding;
	int          hits_seen;
	int          cycle_count = 0;
	int          requests_sent = 0;
	int          settings_used = 0;
	logic [31:0] addr_pool [POOL_SIZE];

	nru_set_assoc_cache_lookup i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.block_address(block_address),
		.done         (done),
		.hit          (hit),
		.way_used     (way_used),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	nru_set_assoc_cache_lookup_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.block_address(block_address),
		.done         (done),
		.hit          (hit),
		.way_used     (way_used),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.hits_seen    (hits_seen)
	);

	always #5 clk = ~clk;

	task automatic issue_lookup(logic [31:0] addr);
		start         <= 1'b1;
		block_address <= addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// stop sending and let every pending request complete
	task automatic drain_lookups();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic reg_sel, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_config(logic [31:0] mask, logic [3:0] ways);
		apb_access(1'b1, nru_pkg::REG_INDEX_MASK, mask);
		apb_access(1'b0, nru_pkg::REG_INDEX_MASK, 32'h0);
		apb_access(1'b1, nru_pkg::REG_WAYS_IN_USE, {28'h0, ways});
		apb_access(1'b0, nru_pkg::REG_WAYS_IN_USE, 32'h0);
		settings_used++;
	endtask

	// four groups agreeing on the selected bits, ten addresses each: more than the ways
	task automatic build_pool(logic [31:0] mask);
		logic [31:0] group_bits [4];
		for (int g = 0; g < 4; g++)
			group_bits[g] = $urandom;
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = ($urandom & ~mask) | (group_bits[i % 4] & mask);
	endtask

	function automatic logic [31:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return addr_pool[$urandom_range(0, POOL_SIZE-1)];
		else if (r < 87)
			return addr_pool[$urandom_range(0, POOL_SIZE-1)] ^ (32'h1 << $urandom_range(0, 31));
		return $urandom;
	endfunction

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("nru_set_assoc_cache_lookup_tb: errors");
		$finish;
	end

	initial begin
		logic [31:0] mask;
		logic [3:0]  ways;
		int          gap_pct;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		block_address <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// clearing pass after reset
		while (busy)
			@(posedge clk);

		// reset settings: fill set 0 past its ways to force the ageing refill
		issue_lookup(32'h0000_0000);
		issue_lookup(32'hffff_ffff);
		issue_lookup(32'h0000_0000);
		for (int k = 1; k <= 8; k++)
			issue_lookup(k << 8);
		issue_lookup(32'h0000_0000);
		issue_lookup(32'h0000_0100);
		issue_lookup(32'h8000_0000);
		issue_lookup(32'hffff_ffff);

		// no index bits, zero ways taken as one
		drain_lookups();
		program_config(32'h0, 4'd0);
		issue_lookup(32'h1234_5678);
		issue_lookup(32'h1234_5678);
		issue_lookup(32'hdead_beef);

		// every bit selected, ways saturated
		drain_lookups();
		program_config(32'hffff_ffff, 4'd15);
		issue_lookup(32'ha5a5_a5a5);
		issue_lookup(32'h5a5a_5a5a);
		issue_lookup(32'ha5a5_a5a5);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_lookups();
			case ($urandom_range(0, 5))
				0: mask = 32'h0;
				1: mask = 32'hffff_ffff;
				2: mask = nru_pkg::INDEX_MASK_RST;
				3: mask = 32'hff00_0000;
				4: mask = $urandom & $urandom;
				default: mask = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: ways = 4'd1;
				1: ways = 4'd8;
				default: ways = $urandom_range(0, 15);
			endcase
			program_config(mask, ways);
			build_pool(mask);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			if (phase == PHASES-1)
				gap_pct = 0;
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				issue_lookup(pick_address());
				if (phase == 3 && i == PHASE_REQUESTS/2)
					drain_lookups();
				else if ($urandom_range(0, 99) < gap_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 11)) @(posedge clk);
				end
			end
		end

		drain_lookups();
		repeat (6) @(posedge clk);
		$display("covered %0d lookups (%0d hits) over %0d register settings",
			requests_sent, hits_seen, settings_used);
		$display("index masks from none to all bits, ways in use 0 to 15, sender gaps 1 to 11");
		if (mismatches == 0 && outstanding == 0)
			$display("nru_set_assoc_cache_lookup_tb: clean");
		else
			$display("nru_set_assoc_cache_lookup_tb: errors");
		$finish;
	end

endmodule
